>>> design/c93enc_pkg.sv
// Shared types, constants and helper functions for the Code 93 encoder.
// Holds the symbol pattern table and the modulo helpers. Has no dependencies.
`default_nettype none

package c93enc_pkg;

   // Code 93 constants.
   localparam logic [5:0] MOD_CHECK    = 6'd47;
   localparam logic [5:0] START_STOP   = 6'd47;
   localparam logic [4:0] C_WEIGHT_MAX = 5'd20;
   localparam logic [3:0] K_WEIGHT_MAX = 4'd15;
   localparam logic [3:0] QUIET_RESET  = 4'd10;

   // Pattern memory geometry: one 24-bit word per symbol, six 4-bit widths.
   localparam int PAT_DEPTH = 48;
   localparam int PAT_AW    = 6;
   localparam int PAT_WIDTH = 24;

   // One input transfer.
   typedef struct packed {
      logic [5:0] symbol_index;
      logic [7:0] message_length;
      logic       first_symbol;
      logic       last_symbol;
   } req_type;

   // One result transfer.
   typedef struct packed {
      logic [3:0] element_width;
      logic       is_bar;
      logic       end_of_code;
      logic       end_of_run;
   } rsp_type;

   // A job held for the sequencer and the check unit.
   typedef struct packed {
      logic [5:0] sym;
      logic       first;
      logic       last;
      logic [4:0] cw_init;
      logic [3:0] kw_init;
   } job_type;

   // One element descriptor between the sequencer and the output stage.
   typedef struct packed {
      logic       from_rom;
      logic [2:0] digit;
      logic [3:0] width;
      logic       is_bar;
      logic       end_of_code;
      logic       end_of_run;
   } elem_type;

   // Pattern word for a symbol; the first element sits in the top nibble.
   function automatic logic [PAT_WIDTH-1:0] pattern_word(input logic [PAT_AW-1:0] idx);
      logic [PAT_WIDTH-1:0] w;
      case (idx)
         6'd0:  w = 24'h131112;
         6'd1:  w = 24'h111213;
         6'd2:  w = 24'h111312;
         6'd3:  w = 24'h111411;
         6'd4:  w = 24'h121113;
         6'd5:  w = 24'h121212;
         6'd6:  w = 24'h121311;
         6'd7:  w = 24'h111114;
         6'd8:  w = 24'h131211;
         6'd9:  w = 24'h141111;
         6'd10: w = 24'h211113;
         6'd11: w = 24'h211212;
         6'd12: w = 24'h211311;
         6'd13: w = 24'h221112;
         6'd14: w = 24'h221211;
         6'd15: w = 24'h231111;
         6'd16: w = 24'h112113;
         6'd17: w = 24'h112212;
         6'd18: w = 24'h112311;
         6'd19: w = 24'h122112;
         6'd20: w = 24'h132111;
         6'd21: w = 24'h111123;
         6'd22: w = 24'h111222;
         6'd23: w = 24'h111321;
         6'd24: w = 24'h121122;
         6'd25: w = 24'h131121;
         6'd26: w = 24'h212112;
         6'd27: w = 24'h212211;
         6'd28: w = 24'h211122;
         6'd29: w = 24'h211221;
         6'd30: w = 24'h221121;
         6'd31: w = 24'h222111;
         6'd32: w = 24'h112122;
         6'd33: w = 24'h112221;
         6'd34: w = 24'h122121;
         6'd35: w = 24'h123111;
         6'd36: w = 24'h121131;
         6'd37: w = 24'h311112;
         6'd38: w = 24'h311211;
         6'd39: w = 24'h321111;
         6'd40: w = 24'h112131;
         6'd41: w = 24'h113121;
         6'd42: w = 24'h211131;
         6'd43: w = 24'h121221;
         6'd44: w = 24'h312111;
         6'd45: w = 24'h311121;
         6'd46: w = 24'h122211;
         default: w = 24'h111141;
      endcase
      return w;
   endfunction

   // Reduces a value below 47 * 32 modulo 47 by binary long division.
   function automatic logic [5:0] mod47(input logic [10:0] x);
      logic [10:0] r;
      r = x;
      for (int k = 4; k >= 0; k--) begin
         if (r >= (11'(MOD_CHECK) << k)) begin
            r = r - (11'(MOD_CHECK) << k);
         end
      end
      return r[5:0];
   endfunction

   // Starting C weight: length modulo 20, where zero gives 20.
   function automatic logic [4:0] cw_start_value(input logic [7:0] len);
      logic [8:0] r;
      r = {1'b0, len};
      for (int k = 3; k >= 0; k--) begin
         if (r >= (9'(C_WEIGHT_MAX) << k)) begin
            r = r - (9'(C_WEIGHT_MAX) << k);
         end
      end
      return (r == 9'd0) ? C_WEIGHT_MAX : r[4:0];
   endfunction

   // Starting K weight: (length + 1) modulo 15, where zero gives 15.
   function automatic logic [3:0] kw_start_value(input logic [7:0] len);
      logic [8:0] r;
      r = {1'b0, len} + 9'd1;
      for (int k = 4; k >= 0; k--) begin
         if (r >= (9'(K_WEIGHT_MAX) << k)) begin
            r = r - (9'(K_WEIGHT_MAX) << k);
         end
      end
      return (r == 9'd0) ? K_WEIGHT_MAX : r[3:0];
   endfunction

endpackage

`default_nettype wire

>>> design/c93enc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module c93enc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 48
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while the read is not enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/c93enc_chk.sv
// Check-symbol unit: keeps the running C and K weights and the C and K sums modulo 47.
// Depends on c93enc_pkg.
`default_nettype none

module c93enc_chk
   import c93enc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire job_type load_job,
   output logic [5:0]   c_check,
   output logic [5:0]   k_check
);

   logic [4:0]  cw_ff, cw_in, cw_use, cw_dec;
   logic [3:0]  kw_ff, kw_in, kw_use, kw_dec;
   logic [5:0]  c_sum_ff, c_sum_in;
   logic [5:0]  k_sum_ff, k_sum_in;
   logic [10:0] prod_c_ff, prod_k_ff;
   logic        p1_valid_ff, p1_last_ff;
   logic [3:0]  kw_chk_ff;
   logic [5:0]  cchk_ff;
   logic [5:0]  ks_hold_ff;
   logic [9:0]  prod_ck_ff;
   logic [5:0]  kchk_ff;
   logic [5:0]  c_new, k_new;

   // Weights for this symbol and their successors.
   always_comb begin
      cw_use = load_job.first ? load_job.cw_init : cw_ff;
      kw_use = load_job.first ? load_job.kw_init : kw_ff;
      cw_dec = (cw_use <= 5'd1) ? C_WEIGHT_MAX : cw_use - 5'd1;
      kw_dec = (kw_use <= 4'd1) ? K_WEIGHT_MAX : kw_use - 4'd1;
      cw_in  = load_job.last ? C_WEIGHT_MAX : cw_dec;
      kw_in  = load_job.last ? K_WEIGHT_MAX : kw_dec;
   end

   // Sum update in the cycle after the products are registered.
   always_comb begin
      c_new    = mod47(11'(c_sum_ff) + prod_c_ff);
      k_new    = mod47(11'(k_sum_ff) + prod_k_ff);
      c_sum_in = c_sum_ff;
      k_sum_in = k_sum_ff;
      if (load && load_job.first) begin
         c_sum_in = '0;
         k_sum_in = '0;
      end else if (p1_valid_ff) begin
         c_sum_in = p1_last_ff ? 6'd0 : c_new;
         k_sum_in = p1_last_ff ? 6'd0 : k_new;
      end
   end

   // Control state and running sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff       <= C_WEIGHT_MAX;
         kw_ff       <= K_WEIGHT_MAX;
         c_sum_ff    <= '0;
         k_sum_ff    <= '0;
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= load;
         c_sum_ff    <= c_sum_in;
         k_sum_ff    <= k_sum_in;
         if (load) begin
            cw_ff <= cw_in;
            kw_ff <= kw_in;
         end
      end
   end

   // Products and check symbols. The check pipeline runs freely and settles
   // well before the sequencer reaches the check patterns.
   always_ff @(posedge clock) begin
      if (load) begin
         prod_c_ff  <= 11'(load_job.sym) * 11'(cw_use);
         prod_k_ff  <= 11'(load_job.sym) * 11'(kw_use);
         p1_last_ff <= load_job.last;
         kw_chk_ff  <= kw_dec;
      end
      if (p1_valid_ff) begin
         cchk_ff    <= c_new;
         ks_hold_ff <= k_new;
      end
      prod_ck_ff <= 10'(cchk_ff) * 10'(kw_chk_ff);
      kchk_ff    <= mod47(11'(ks_hold_ff) + 11'(prod_ck_ff));
   end

   assign c_check = cchk_ff;
   assign k_check = kchk_ff;

endmodule

`default_nettype wire

>>> design/c93enc_seq.sv
// Element sequencer: walks one job through quiet zones, patterns and checks,
// issuing one element and one pattern-memory read per cycle while adv is high.
// Depends on c93enc_pkg.
`default_nettype none

module c93enc_seq
   import c93enc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              pend_valid,
   input  wire job_type           pend_job,
   input  wire logic [5:0]        c_check,
   input  wire logic [5:0]        k_check,
   input  wire logic [3:0]        quiet_width,
   output logic                   load,
   output logic                   issue_valid,
   output elem_type               issue_elem,
   output logic [PAT_AW-1:0]      rd_addr
);

   localparam logic [2:0] PH_QLEFT  = 3'd0;
   localparam logic [2:0] PH_START  = 3'd1;
   localparam logic [2:0] PH_DATA   = 3'd2;
   localparam logic [2:0] PH_CCHK   = 3'd3;
   localparam logic [2:0] PH_KCHK   = 3'd4;
   localparam logic [2:0] PH_STOP   = 3'd5;
   localparam logic [2:0] PH_TERM   = 3'd6;
   localparam logic [2:0] PH_QRIGHT = 3'd7;

   localparam logic [2:0] LAST_DIGIT = 3'd5;

   logic        job_valid_ff;
   job_type     job_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  digit_ff, digit_in;
   logic        bar_phase_ff;
   logic        issue_last;
   logic        pat_end;
   logic [3:0]  quiet_elem;

   assign quiet_elem = (quiet_width == 4'd0) ? 4'd1 : quiet_width;
   assign pat_end    = (digit_ff == LAST_DIGIT);

   // Descriptor and memory address for the current element.
   always_comb begin
      issue_elem             = '0;
      issue_elem.digit       = digit_ff;
      issue_elem.is_bar      = bar_phase_ff;
      issue_elem.from_rom    = 1'b1;
      rd_addr                = START_STOP;
      issue_last             = 1'b0;
      case (phase_ff)
         PH_QLEFT: begin
            issue_elem.from_rom = 1'b0;
            issue_elem.width    = quiet_elem;
         end
         PH_DATA: begin
            rd_addr    = job_ff.sym;
            issue_last = pat_end && !job_ff.last;
         end
         PH_CCHK:  rd_addr = c_check;
         PH_KCHK:  rd_addr = k_check;
         PH_TERM: begin
            issue_elem.from_rom = 1'b0;
            issue_elem.width    = 4'd1;
         end
         PH_QRIGHT: begin
            issue_elem.from_rom    = 1'b0;
            issue_elem.width       = quiet_elem;
            issue_elem.end_of_code = 1'b1;
            issue_last             = 1'b1;
         end
         default: rd_addr = START_STOP;
      endcase
      issue_elem.end_of_run = issue_last;
   end

   // Next position within the job.
   always_comb begin
      phase_in = phase_ff;
      digit_in = digit_ff + 3'd1;
      case (phase_ff)
         PH_QLEFT: begin
            phase_in = PH_START;
            digit_in = '0;
         end
         PH_START, PH_DATA, PH_CCHK, PH_KCHK, PH_STOP: begin
            if (pat_end) begin
               phase_in = phase_ff + 3'd1;
               digit_in = '0;
            end
         end
         PH_TERM: begin
            phase_in = PH_QRIGHT;
            digit_in = '0;
         end
         default: begin
            phase_in = phase_ff;
            digit_in = '0;
         end
      endcase
   end

   assign issue_valid = job_valid_ff;
   assign load        = pend_valid && (!job_valid_ff || (adv && issue_last));

   // Job, position and bar/space phase. A new message restarts on a space.
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         bar_phase_ff <= 1'b0;
         phase_ff     <= PH_DATA;
         digit_ff     <= '0;
      end else begin
         if (load && pend_job.first) begin
            bar_phase_ff <= 1'b0;
         end else if (adv && job_valid_ff) begin
            bar_phase_ff <= ~bar_phase_ff;
         end
         if (load) begin
            job_valid_ff <= 1'b1;
            phase_ff     <= pend_job.first ? PH_QLEFT : PH_DATA;
            digit_ff     <= '0;
         end else if (adv && job_valid_ff) begin
            if (issue_last) begin
               job_valid_ff <= 1'b0;
            end else begin
               phase_ff <= phase_in;
               digit_ff <= digit_in;
            end
         end
      end
   end

   // Job payload.
   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= pend_job;
      end
   end

endmodule

`default_nettype wire

>>> design/code93_barcode_encoder.sv
// Top level of the Code 93 encoder: input register, pattern memory and its
// fill, output stage. Depends on c93enc_pkg, c93enc_ram, c93enc_chk, c93enc_seq.
//
//   Channel  Ports                             Moves
//   req      req_valid, req_stall, req_data    one symbol with length and marks
//   rsp      rsp_valid, rsp_stall, rsp_data    one bar or space width
//   csr      csr_wr_en, csr_wr_data            quiet zone width
//
// One element leaves per cycle while rsp_stall is low, one pattern-memory read each:
// a symbol in the middle of a message gives 6 elements, a first symbol 13, a last
// one 26, and a symbol that is both first and last 33.
// After reset the pattern memory is filled from the pattern table; req_stall is high while it fills.
// rsp_stall freezes the sequencer and the output stage; one further input
// transfer is held in the input register meanwhile.
`default_nettype none

module code93_barcode_encoder
   import c93enc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_wr_en,
   input  wire logic [3:0] csr_wr_data
);

   logic [3:0]           quiet_width_ff;
   logic                 filling_ff;
   logic [PAT_AW-1:0]    fill_cnt_ff;
   logic                 pend_valid_ff;
   job_type              pend_job_ff;
   logic [5:0]           sym_sat;
   logic                 adv;
   logic                 load;
   logic                 issue_valid;
   elem_type             issue_elem;
   logic [PAT_AW-1:0]    rd_addr;
   logic [PAT_WIDTH-1:0] rd_data;
   logic [5:0]           c_check, k_check;
   logic                 b_valid_ff;
   elem_type             elem_b_ff;
   logic [3:0]           b_width;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   logic                 req_xfer;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         quiet_width_ff <= QUIET_RESET;
      end else if (csr_wr_en) begin
         quiet_width_ff <= csr_wr_data;
      end
   end

   // Pattern memory fill after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         filling_ff  <= 1'b1;
         fill_cnt_ff <= '0;
      end else if (filling_ff) begin
         fill_cnt_ff <= fill_cnt_ff + PAT_AW'(1);
         if (fill_cnt_ff == PAT_AW'(PAT_DEPTH - 1)) begin
            filling_ff <= 1'b0;
         end
      end
   end

   // Input register; out-of-range symbols saturate to start/stop.
   assign req_stall = filling_ff || pend_valid_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign sym_sat   = (req_data.symbol_index > START_STOP) ? START_STOP
                                                           : req_data.symbol_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         pend_valid_ff <= 1'b1;
      end else if (load) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pend_job_ff.sym     <= sym_sat;
         pend_job_ff.first   <= req_data.first_symbol;
         pend_job_ff.last    <= req_data.last_symbol;
         pend_job_ff.cw_init <= cw_start_value(req_data.message_length);
         pend_job_ff.kw_init <= kw_start_value(req_data.message_length);
      end
   end

   // The whole element pipeline moves when the output register can take data.
   assign adv = !rsp_valid_ff || !rsp_stall;

   c93enc_chk u_chk (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .load_job (pend_job_ff),
      .c_check  (c_check),
      .k_check  (k_check)
   );

   c93enc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .pend_valid  (pend_valid_ff),
      .pend_job    (pend_job_ff),
      .c_check     (c_check),
      .k_check     (k_check),
      .quiet_width (quiet_width_ff),
      .load        (load),
      .issue_valid (issue_valid),
      .issue_elem  (issue_elem),
      .rd_addr     (rd_addr)
   );

   c93enc_ram #(
      .WIDTH (PAT_WIDTH),
      .DEPTH (PAT_DEPTH)
   ) u_pat_ram (
      .clock   (clock),
      .wr_en   (filling_ff),
      .wr_addr (fill_cnt_ff),
      .wr_data (pattern_word(fill_cnt_ff)),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Element stage aligned with the memory read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= issue_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         elem_b_ff <= issue_elem;
      end
   end

   // Pick the width nibble of the pattern, or the fixed width.
   always_comb begin
      case (elem_b_ff.digit)
         3'd0:    b_width = rd_data[23:20];
         3'd1:    b_width = rd_data[19:16];
         3'd2:    b_width = rd_data[15:12];
         3'd3:    b_width = rd_data[11:8];
         3'd4:    b_width = rd_data[7:4];
         default: b_width = rd_data[3:0];
      endcase
      if (!elem_b_ff.from_rom) begin
         b_width = elem_b_ff.width;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.element_width <= b_width;
         rsp_data_ff.is_bar        <= elem_b_ff.is_bar;
         rsp_data_ff.end_of_code   <= elem_b_ff.end_of_code;
         rsp_data_ff.end_of_run    <= elem_b_ff.end_of_run;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
